// ----- src/frame_difference_motion_alarm_core_macros.svh -----
// Assertion helpers shared by the motion alarm RTL.
// Both sample on the rising edge of clk and are quiet while rst_n is low.
`ifndef FRAME_DIFFERENCE_MOTION_ALARM_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_ALARM_CORE_MACROS_SVH

// General property check.
`define FDMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true.
`define FDMA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- src/fdma_pkg.sv -----
`timescale 1ns / 1ps

package fdma_pkg;

  // Size of the reference frame store, in pixels.
  localparam int unsigned MAX_PIXELS = 65536;
  localparam int unsigned ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  // Counts scaled by a percentage (up to 127) still fit here.
  localparam int unsigned PROD_W     = CNT_W + 7;
  localparam int unsigned OUT_CNT_W  = 17;

  localparam int unsigned GRAY_SUM_W = 22;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] COEF_B   = GRAY_SUM_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] COEF_G   = GRAY_SUM_W'(9617);
  localparam logic [GRAY_SUM_W-1:0] COEF_R   = GRAY_SUM_W'(4899);
  localparam logic [GRAY_SUM_W-1:0] GRAY_RND = GRAY_SUM_W'(8192);

  localparam logic [PROD_W-1:0] PERCENT_SCALE = PROD_W'(100);

  typedef logic [1:0] action_t;
  localparam action_t ACT_PIXEL = 2'd0;
  localparam action_t ACT_TICK  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DIFF_THRESHOLD = 2'd0;
  localparam reg_idx_t REG_RATIO_PERCENT  = 2'd1;
  localparam reg_idx_t REG_HOLDOFF_MS     = 2'd2;

  localparam logic [7:0]  RST_DIFF_THRESHOLD = 8'd30;
  localparam logic [6:0]  RST_RATIO_PERCENT  = 7'd10;
  localparam logic [15:0] RST_HOLDOFF_MS     = 16'd3000;

  // One pixel item on its way from the input register to the result logic.
  typedef struct packed {
    action_t             action;
    logic                last;
    logic                in_range;
    logic                cmp;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          gray;
    logic [CNT_W-1:0]    total;
    logic [PROD_W-1:0]   ratio_total;
  } stage_t;

  function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [GRAY_SUM_W-1:0] sum;
    sum = COEF_B * GRAY_SUM_W'(b) + COEF_G * GRAY_SUM_W'(g) + COEF_R * GRAY_SUM_W'(r)
          + GRAY_RND;
    return sum[GRAY_SHIFT +: 8];
  endfunction

endpackage

// ----- src/frame_difference_motion_alarm_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    action, blue, green, red, last_of_frame
// out_      output     out_valid / out_stall  frame_status, changed_count, pixel_count,
//                                             motion, alarm
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock while in_stall is low. In the input stage the gray value is formed
// and the reference store is read; in the compare stage the store is written back and
// the counts are updated; a result then passes from there into the output register.
// The single-port-per-direction reference store sets that rate.
// Reset (rst_n low, synchronous) clears control state; the store itself needs no clearing.
// in_stall rises only while a result in the compare stage waits on a full, stalled output register.

module frame_difference_motion_alarm_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  fdma_pkg::action_t       in_action,
  input  logic [7:0]              in_blue,
  input  logic [7:0]              in_green,
  input  logic [7:0]              in_red,
  input  logic                    in_last_of_frame,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_frame_status,
  output logic [16:0]             out_changed_count,
  output logic [16:0]             out_pixel_count,
  output logic                    out_motion,
  output logic                    out_alarm,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  fdma_pkg::reg_idx_t      cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int unsigned ADDR_W = fdma_pkg::ADDR_W;
  localparam int unsigned CNT_W  = fdma_pkg::CNT_W;
  localparam int unsigned PROD_W = fdma_pkg::PROD_W;

  // Configuration registers
  logic [7:0]  diff_threshold_r;
  logic [6:0]  ratio_percent_r;
  logic [15:0] holdoff_ms_r;

  // Input-side state
  logic [CNT_W-1:0] pixel_index_r;
  logic             ref_valid_r;

  // Compare stage
  logic             s1_valid_r;
  fdma_pkg::stage_t s1_r;
  fdma_pkg::stage_t s1_nxt;
  logic [7:0]       rd_r;
  logic             fwd_r;
  logic [7:0]       fwd_data_r;

  // Result-side state
  logic [CNT_W-1:0]  changed_total_r;
  logic [PROD_W-1:0] changed_x100_r;
  logic              motion_flag_r;
  logic [15:0]       holdoff_left_r;

  // Output register
  logic              out_valid_r;
  logic              out_frame_status_r;
  logic [16:0]       out_changed_count_r;
  logic [16:0]       out_pixel_count_r;
  logic              out_motion_r;
  logic              out_alarm_r;

  logic [7:0] ref_store [fdma_pkg::MAX_PIXELS];

  logic              in_acc;
  logic              in_range;
  logic [CNT_W-1:0]  idx_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic              s1_pixel;
  logic              s1_result;
  logic              s1_go;
  logic              wr_en;
  logic [7:0]        rd_val;
  logic [7:0]        diff;
  logic              hit;
  logic [CNT_W-1:0]  changed_new;
  logic [PROD_W-1:0] changed_x100_new;
  logic              motion_calc;
  logic              alarm_calc;
  logic              out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_threshold_r <= fdma_pkg::RST_DIFF_THRESHOLD;
      ratio_percent_r  <= fdma_pkg::RST_RATIO_PERCENT;
      holdoff_ms_r     <= fdma_pkg::RST_HOLDOFF_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdma_pkg::REG_DIFF_THRESHOLD: diff_threshold_r <= cfg_data[7:0];
        fdma_pkg::REG_RATIO_PERCENT:  ratio_percent_r  <= cfg_data[6:0];
        fdma_pkg::REG_HOLDOFF_MS:     holdoff_ms_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- Input stage ----------------
  assign in_acc   = in_valid && !in_stall;
  assign in_range = pixel_index_r < CNT_W'(fdma_pkg::MAX_PIXELS);
  assign idx_inc  = pixel_index_r + CNT_W'(in_range);
  assign rd_addr  = pixel_index_r[ADDR_W-1:0];

  always_comb begin
    s1_nxt.action      = in_action;
    s1_nxt.last        = in_last_of_frame;
    s1_nxt.in_range    = in_range;
    s1_nxt.cmp         = ref_valid_r;
    s1_nxt.addr        = rd_addr;
    s1_nxt.gray        = fdma_pkg::gray_of(in_blue, in_green, in_red);
    s1_nxt.total       = idx_inc;
    s1_nxt.ratio_total = PROD_W'(ratio_percent_r) * PROD_W'(idx_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_index_r <= '0;
      ref_valid_r   <= 1'b0;
    end else if (in_acc) begin
      case (in_action)
        fdma_pkg::ACT_PIXEL: begin
          if (in_last_of_frame) begin
            pixel_index_r <= '0;
            ref_valid_r   <= 1'b1;
          end else begin
            pixel_index_r <= idx_inc;
          end
        end
        fdma_pkg::ACT_CLEAR: begin
          pixel_index_r <= '0;
          ref_valid_r   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Reference store: one registered read for the incoming pixel, one write from the
  // compare stage. A read of the entry written in the same cycle takes the new value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_store[s1_r.addr] <= s1_r.gray;
    end
    if (in_acc) begin
      rd_r <= ref_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= s1_r.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= wr_en && (s1_r.addr == rd_addr);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- Compare stage ----------------
  assign s1_pixel  = s1_r.action == fdma_pkg::ACT_PIXEL;
  assign s1_result = s1_valid_r && s1_pixel && s1_r.last;
  assign out_take  = out_valid_r && !out_stall;
  assign s1_go     = s1_valid_r && (!s1_result || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign wr_en     = s1_go && s1_pixel && s1_r.in_range;

  assign rd_val = fwd_r ? fwd_data_r : rd_r;
  assign diff   = (s1_r.gray >= rd_val) ? (s1_r.gray - rd_val) : (rd_val - s1_r.gray);
  assign hit    = s1_pixel && s1_r.in_range && s1_r.cmp && (diff > diff_threshold_r);

  // The percentage test compares changed*100 against ratio*total; the left side is
  // kept as a running sum so no multiplier sits behind the difference logic.
  assign changed_new      = changed_total_r + CNT_W'(hit);
  assign changed_x100_new = changed_x100_r + (hit ? fdma_pkg::PERCENT_SCALE : '0);
  assign motion_calc      = (s1_r.total != '0) && (changed_x100_new >= s1_r.ratio_total);
  assign alarm_calc       = motion_calc && !motion_flag_r && (holdoff_left_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_total_r <= '0;
      changed_x100_r  <= '0;
      motion_flag_r   <= 1'b0;
      holdoff_left_r  <= '0;
    end else if (s1_go) begin
      case (s1_r.action)
        fdma_pkg::ACT_TICK: begin
          if (holdoff_left_r != '0) begin
            holdoff_left_r <= holdoff_left_r - 16'd1;
          end
        end
        fdma_pkg::ACT_CLEAR: begin
          changed_total_r <= '0;
          changed_x100_r  <= '0;
          motion_flag_r   <= 1'b0;
        end
        fdma_pkg::ACT_PIXEL: begin
          if (s1_r.last) begin
            changed_total_r <= '0;
            changed_x100_r  <= '0;
            if (s1_r.cmp) begin
              motion_flag_r <= motion_calc;
              if (alarm_calc) begin
                holdoff_left_r <= holdoff_ms_r;
              end
            end
          end else begin
            changed_total_r <= changed_new;
            changed_x100_r  <= changed_x100_new;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- Output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_result) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // A reference frame reports zero counts and the held motion state.
  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      out_frame_status_r  <= !s1_r.cmp;
      out_changed_count_r <= s1_r.cmp ? fdma_pkg::OUT_CNT_W'(changed_new) : '0;
      out_pixel_count_r   <= s1_r.cmp ? fdma_pkg::OUT_CNT_W'(s1_r.total) : '0;
      out_motion_r        <= s1_r.cmp ? motion_calc : motion_flag_r;
      out_alarm_r         <= s1_r.cmp && alarm_calc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_status  = out_frame_status_r;
  assign out_changed_count = out_changed_count_r;
  assign out_pixel_count   = out_pixel_count_r;
  assign out_motion        = out_motion_r;
  assign out_alarm         = out_alarm_r;

  // ---------------- Assertions ----------------
`include "frame_difference_motion_alarm_core_macros.svh"

  `FDMA_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_r, "input stalled with empty stage")
  `FDMA_NEVER(a_index_bound, pixel_index_r > CNT_W'(fdma_pkg::MAX_PIXELS), "pixel index overrun")
  `FDMA_ASSERT(a_alarm_with_motion, out_valid_r && out_alarm_r |-> out_motion_r && !out_frame_status_r, "alarm without motion")
  `FDMA_ASSERT(a_alarm_loads_holdoff, s1_go && s1_result && s1_r.cmp && alarm_calc |=> holdoff_left_r == $past(holdoff_ms_r), "holdoff not reloaded on alarm")
  `FDMA_NEVER(a_ref_counts_zero, out_valid_r && out_frame_status_r && (out_alarm_r || out_pixel_count_r != '0), "reference frame with counts")

endmodule

// ----- verif/frame_difference_motion_alarm_core_test.sv -----
`timescale 1ns / 1ps

module frame_difference_motion_alarm_core_test;

  // Code 3 of the action field does nothing in the block.
  localparam fdma_pkg::action_t ACT_IGNORED = 2'd3;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    fdma_pkg::action_t action;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              last;
  } stream_item_t;

  typedef struct packed {
    logic        frame_status;
    logic [16:0] changed_count;
    logic [16:0] pixel_count;
    logic        motion;
    logic        alarm;
  } frame_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fdma_pkg::action_t  in_action = fdma_pkg::ACT_PIXEL;
  logic [7:0]         in_blue = 8'd0;
  logic [7:0]         in_green = 8'd0;
  logic [7:0]         in_red = 8'd0;
  logic               in_last_of_frame = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_frame_status;
  logic [16:0]        out_changed_count;
  logic [16:0]        out_pixel_count;
  logic               out_motion;
  logic               out_alarm;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  fdma_pkg::reg_idx_t cfg_index = fdma_pkg::REG_DIFF_THRESHOLD;
  logic [15:0]        cfg_data = 16'd0;

  frame_difference_motion_alarm_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_changed_count (out_changed_count),
    .out_pixel_count   (out_pixel_count),
    .out_motion        (out_motion),
    .out_alarm         (out_alarm),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stream_item_t  pending_items[$];
  frame_report_t frame_reports[$];
  stream_item_t  on_port;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  logic          no_gaps = 1'b0;
  logic          pressure_on = 1'b0;
  logic          hold_done = 1'b0;
  int unsigned   hold_left = 0;

  // Predicted block state and its register settings.
  logic [7:0]    thr_cfg = fdma_pkg::RST_DIFF_THRESHOLD;
  logic [6:0]    ratio_cfg = fdma_pkg::RST_RATIO_PERCENT;
  logic [15:0]   holdoff_cfg = fdma_pkg::RST_HOLDOFF_MS;
  logic [7:0]    gray_mem [0:fdma_pkg::MAX_PIXELS-1];
  logic          ref_loaded = 1'b0;
  int unsigned   pix_idx = 0;
  int unsigned   changed_acc = 0;
  logic          motion_held = 1'b0;
  logic [15:0]   holdoff_left = 16'd0;

  // What the stimulus side knows of the scene, so that no compare ever reads an
  // entry of the store that was never written.
  logic [23:0]   scene_bgr [0:fdma_pkg::MAX_PIXELS-1];
  logic          gen_ref_valid = 1'b0;
  int unsigned   gen_idx = 0;
  int unsigned   gen_written = 0;
  int unsigned   gen_count = 0;

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic logic [7:0] luma8(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r);
    int unsigned acc;
    acc = 1868 * int'(b) + 9617 * int'(g) + 4899 * int'(r) + 8192;
    return 8'(acc >> 14);
  endfunction

  task automatic update_motion_model(input stream_item_t it);
    frame_report_t    rep;
    logic [7:0]       gray;
    logic [7:0]       old;
    int unsigned      delta;
    longint unsigned  lhs;
    longint unsigned  rhs;
    logic             mot;
    case (it.action)
      fdma_pkg::ACT_TICK: begin
        if (holdoff_left != 16'd0) holdoff_left = holdoff_left - 16'd1;
      end
      fdma_pkg::ACT_CLEAR: begin
        ref_loaded = 1'b0;
        motion_held = 1'b0;
        pix_idx = 0;
        changed_acc = 0;
      end
      fdma_pkg::ACT_PIXEL: begin
        if (pix_idx < fdma_pkg::MAX_PIXELS) begin
          gray = luma8(it.blue, it.green, it.red);
          if (ref_loaded) begin
            old = gray_mem[pix_idx];
            delta = (gray > old) ? int'(gray - old) : int'(old - gray);
            if (delta > int'(thr_cfg)) changed_acc++;
          end
          gray_mem[pix_idx] = gray;
          pix_idx++;
        end
        if (it.last) begin
          rep = '0;
          if (!ref_loaded) begin
            rep.frame_status = 1'b1;
            rep.motion = motion_held;
            ref_loaded = 1'b1;
          end else begin
            lhs = 64'(changed_acc) * 64'd100;
            rhs = 64'(ratio_cfg) * 64'(pix_idx);
            mot = (pix_idx > 0) && (lhs >= rhs);
            if (mot && !motion_held && holdoff_left == 16'd0) begin
              rep.alarm = 1'b1;
              holdoff_left = holdoff_cfg;
            end
            motion_held = mot;
            rep.changed_count = 17'(changed_acc);
            rep.pixel_count = 17'(pix_idx);
            rep.motion = mot;
          end
          pix_idx = 0;
          changed_acc = 0;
          frame_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : drive_items
    stream_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) update_motion_model(on_port);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !take_gap()) begin
          nxt = pending_items.pop_front();
          on_port = nxt;
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_blue <= nxt.blue;
          in_green <= nxt.green;
          in_red <= nxt.red;
          in_last_of_frame <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold of the result channel once the pressure phase begins.
  always @(posedge clk) begin : hold_results
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_reports
    frame_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_reports.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected report: status %0d changed %0d pixels %0d motion %0d alarm %0d",
                   out_frame_status, out_changed_count, out_pixel_count, out_motion,
                   out_alarm);
        mismatches++;
      end else begin
        want = frame_reports.pop_front();
        if (out_frame_status !== want.frame_status || out_changed_count !== want.changed_count
            || out_pixel_count !== want.pixel_count || out_motion !== want.motion
            || out_alarm !== want.alarm) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: expected status %0d changed %0d pixels %0d motion %0d alarm %0d",
                     want.frame_status, want.changed_count, want.pixel_count, want.motion,
                     want.alarm);
            $display("mismatch: actual   status %0d changed %0d pixels %0d motion %0d alarm %0d",
                     out_frame_status, out_changed_count, out_pixel_count, out_motion,
                     out_alarm);
          end
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ((hold_left != 0) || take_gap());
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_difference_motion_alarm_core test failed");
      $finish;
    end
  end

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit last, output bit ended);
    stream_item_t it;
    ended = last;
    if (gen_idx < fdma_pkg::MAX_PIXELS) begin
      scene_bgr[gen_idx] = {b, g, r};
      gen_idx++;
      if (gen_idx > gen_written) gen_written = gen_idx;
      // The next pixel would be compared against an entry never written.
      if (gen_ref_valid && gen_idx < fdma_pkg::MAX_PIXELS && gen_idx >= gen_written)
        ended = 1'b1;
    end
    it.action = fdma_pkg::ACT_PIXEL;
    it.blue = b;
    it.green = g;
    it.red = r;
    it.last = ended;
    pending_items.push_back(it);
    gen_count++;
    if (ended) begin
      gen_ref_valid = 1'b1;
      gen_idx = 0;
    end
  endtask

  task automatic push_ctrl(input fdma_pkg::action_t act);
    stream_item_t it;
    it.action = act;
    it.blue = 8'($urandom);
    it.green = 8'($urandom);
    it.red = 8'($urandom);
    it.last = 1'($urandom);
    pending_items.push_back(it);
    if (act != ACT_IGNORED) gen_count++;
    if (act == fdma_pkg::ACT_CLEAR) begin
      gen_ref_valid = 1'b0;
      gen_idx = 0;
    end
  endtask

  // Repeats the stored pixel unless it is picked for a change, which is either a
  // small shift of green (near the threshold) or a fresh random color.
  task automatic push_scene_pixel(input int unsigned change_pct, input bit last,
                                  output bit ended);
    logic [23:0] bgr;
    int unsigned roll;
    int          shifted;
    bgr = 24'($urandom);
    if (gen_ref_valid && gen_idx < fdma_pkg::MAX_PIXELS) begin
      roll = $urandom_range(0, 99);
      if (roll >= change_pct) begin
        bgr = scene_bgr[gen_idx];
      end else if (roll[0]) begin
        bgr = scene_bgr[gen_idx];
        shifted = int'(bgr[15:8]) + int'($urandom_range(0, 120)) - 60;
        bgr[15:8] = (shifted < 0) ? 8'd0 : (shifted > 255) ? 8'd255 : 8'(shifted);
      end
    end
    push_pixel(bgr[23:16], bgr[15:8], bgr[7:0], last, ended);
  endtask

  task automatic gen_frame(input int unsigned len, input int unsigned change_pct);
    bit ended;
    for (int unsigned i = 0; i < len; i++) begin
      push_scene_pixel(change_pct, i == len - 1, ended);
      if (ended) break;
    end
  endtask

  task automatic push_flat_frame(input int unsigned len, input logic [7:0] level);
    bit ended;
    for (int unsigned i = 0; i < len; i++) begin
      push_pixel(level, level, level, i == len - 1, ended);
      if (ended) break;
    end
  endtask

  task automatic gen_random(input int unsigned n, input int unsigned maxlen);
    int unsigned start;
    int unsigned roll;
    bit          ended;
    start = gen_count;
    while (gen_count - start < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        gen_frame($urandom_range(1, maxlen), $urandom_range(0, 100));
      end else if (roll < 86) begin
        repeat ($urandom_range(1, 4)) push_ctrl(fdma_pkg::ACT_TICK);
      end else if (roll < 91) begin
        push_ctrl(fdma_pkg::ACT_CLEAR);
      end else if (roll < 95) begin
        push_ctrl(ACT_IGNORED);
      end else begin
        // A frame cut short by a clear.
        repeat ($urandom_range(1, 4)) push_scene_pixel($urandom_range(0, 100), 1'b0, ended);
        push_ctrl(fdma_pkg::ACT_CLEAR);
      end
    end
  endtask

  task automatic write_reg(input fdma_pkg::reg_idx_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fdma_pkg::REG_DIFF_THRESHOLD: thr_cfg = data[7:0];
      fdma_pkg::REG_RATIO_PERCENT:  ratio_cfg = data[6:0];
      fdma_pkg::REG_HOLDOFF_MS:     holdoff_cfg = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || frame_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    bit ended;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a tick at zero holdoff, an ignored code, a reference frame,
    // motion with an alarm, motion falling, motion rising inside the holdoff, and a
    // clear in the middle of a frame.
    push_ctrl(fdma_pkg::ACT_TICK);
    push_ctrl(ACT_IGNORED);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0, ended);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b1, ended);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b1, ended);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b1, ended);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0, ended);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0, ended);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b0, ended);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b1, ended);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0, ended);
    push_ctrl(fdma_pkg::ACT_CLEAR);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b1, ended);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1, ended);
    settle();

    // Every pixel counts as changed on any difference, all must change for motion,
    // and the holdoff is short enough to run out through ticks.
    write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'd0);
    write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'd100);
    write_reg(fdma_pkg::REG_HOLDOFF_MS, 16'd2);
    push_ctrl(fdma_pkg::ACT_CLEAR);
    push_flat_frame(2, 8'd0);
    push_flat_frame(2, 8'd255);
    push_ctrl(fdma_pkg::ACT_TICK);
    push_flat_frame(2, 8'd255);
    push_flat_frame(2, 8'd0);
    push_ctrl(fdma_pkg::ACT_TICK);
    push_ctrl(fdma_pkg::ACT_TICK);
    push_flat_frame(2, 8'd255);
    push_flat_frame(2, 8'd255);
    push_flat_frame(2, 8'd0);
    gen_random(120, 12);
    settle();

    write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'd255);
    write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'd0);
    write_reg(fdma_pkg::REG_HOLDOFF_MS, 16'd65535);
    gen_random(100, 40);
    settle();

    // No idling on either side in this phase.
    no_gaps <= 1'b1;
    write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'($urandom));
    write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'd127);
    write_reg(fdma_pkg::REG_HOLDOFF_MS, 16'd0);
    gen_random(120, 12);
    settle();

    // Short frames against a long hold of the result side fill the block up.
    write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'd20);
    write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'd50);
    pressure_on <= 1'b1;
    gen_random(120, 3);
    settle();
    no_gaps <= 1'b0;

    // A fresh reference followed by a partly changed frame, with a one tick holdoff.
    write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'd40);
    write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'd25);
    write_reg(fdma_pkg::REG_HOLDOFF_MS, 16'd1);
    push_ctrl(fdma_pkg::ACT_CLEAR);
    gen_frame(24, 0);
    gen_frame(24, 30);
    settle();

    repeat (3) begin
      write_reg(fdma_pkg::REG_DIFF_THRESHOLD, 16'($urandom));
      write_reg(fdma_pkg::REG_RATIO_PERCENT, 16'($urandom));
      write_reg(fdma_pkg::REG_HOLDOFF_MS, 16'($urandom_range(0, 8)));
      gen_random(50, 16);
      settle();
    end

    if (mismatches == 0 && frame_reports.size() == 0) begin
      $display("frame_difference_motion_alarm_core test passed");
    end else begin
      $display("frame_difference_motion_alarm_core test failed");
    end
    $finish;
  end

endmodule
